// File: design/mcfr_pkg.sv
// Package for the motion command framer and reply checker.
// Holds sizes, codes and payload types; no dependencies.
package mcfr_pkg;

   localparam int MAX_ARG_BYTES   = 4;
   localparam int MAX_REPLY_BYTES = 8;
   localparam int FRAME_BYTES     = 4 + MAX_ARG_BYTES;
   localparam int IDX_W           = $clog2(FRAME_BYTES);
   localparam int CNT_W           = $clog2(FRAME_BYTES + 1);
   localparam int ARG_CNT_W       = $clog2(MAX_ARG_BYTES + 1);

   localparam logic FUNC_CMD   = 1'b0;
   localparam logic FUNC_REPLY = 1'b1;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_RX = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DEV  = 2'd1;
   localparam logic [1:0] STATUS_CSUM = 2'd2;

   localparam logic [7:0] BYTE_ZERO  = 8'h00;
   localparam logic [7:0] BYTE_ONE   = 8'h01;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] status_type;
   typedef logic [3:0] rlen_type;

endpackage

// File: design/mcfr_req_if.sv
// Input channel: command items and received reply bytes.
// Depends on mcfr_pkg.
interface mcfr_req_if import mcfr_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        func;
   byte_type    address;
   byte_type    opcode;
   logic [2:0]  arg_bytes;
   logic [31:0] arg_value;
   rlen_type    response_length;
   byte_type    rx_byte;

   modport source (output valid, func, address, opcode, arg_bytes, arg_value,
                   response_length, rx_byte, input ready);
   modport sink   (input valid, func, address, opcode, arg_bytes, arg_value,
                   response_length, rx_byte, output ready);
endinterface

// File: design/mcfr_rsp_if.sv
// Result channel: transmitted frame bytes and echoed reply bytes.
// Depends on mcfr_pkg.
interface mcfr_rsp_if import mcfr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       kind;
   byte_type   byte_value;
   logic       last;
   status_type status;

   modport source (output valid, kind, byte_value, last, status, input ready);
   modport sink   (input valid, kind, byte_value, last, status, output ready);
endinterface

// File: design/motion_cmd_frame_and_reply_check_unit.sv
// Motion command framer and reply checker, top level.
// Depends on mcfr_pkg, mcfr_req_if, mcfr_rsp_if.
// Each item passes through the work register and then the output register.
// Throughput: a command leaves the work register one frame byte per cycle while
// the output is not stalled; the next item is taken as its last byte advances.
// Reset: synchronous; empties both stages and disarms the reply.
module motion_cmd_frame_and_reply_check_unit import mcfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mcfr_req_if.sink   req_port,
   mcfr_rsp_if.source rsp_port
);

   logic                 reply_active_ff, reply_active_in;
   rlen_type             reply_remaining_ff, reply_remaining_in;
   logic                 reply_first_ff, reply_first_in;
   byte_type             reply_sum_ff, reply_sum_in;

   logic                 wk_valid_ff, wk_valid_in;
   logic                 wk_kind_ff, wk_kind_in;
   byte_type             wk_bytes_ff [FRAME_BYTES];
   byte_type             wk_bytes_in [FRAME_BYTES];
   logic [IDX_W-1:0]     wk_idx_ff, wk_idx_in;
   logic [IDX_W-1:0]     wk_last_idx_ff, wk_last_idx_in;
   logic                 wk_end_ff, wk_end_in;
   status_type           wk_status_ff, wk_status_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_kind_ff, out_kind_in;
   byte_type             out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   status_type           out_status_ff, out_status_in;

   logic                 adv;
   logic                 wk_at_last;
   logic                 req_fire;
   logic [ARG_CNT_W-1:0] arg_cnt;
   logic [CNT_W-1:0]     total;
   byte_type             arg_b [MAX_ARG_BYTES];
   byte_type             frame_sum;
   byte_type             rx_sum;
   rlen_type             rlen_sat;
   rlen_type             rem_dec;

   assign adv        = !out_valid_ff || rsp_port.ready;
   assign wk_at_last = (wk_idx_ff == wk_last_idx_ff);
   assign req_port.ready = !wk_valid_ff || (adv && wk_at_last);
   assign req_fire   = req_port.valid && req_port.ready;

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.kind       = out_kind_ff;
   assign rsp_port.byte_value = out_byte_ff;
   assign rsp_port.last       = out_last_ff;
   assign rsp_port.status     = out_status_ff;

   // frame construction
   always_comb begin
      int pos;
      pos = 0;
      if (int'(req_port.arg_bytes) > MAX_ARG_BYTES) begin
         arg_cnt = ARG_CNT_W'(MAX_ARG_BYTES);
      end else begin
         arg_cnt = ARG_CNT_W'(req_port.arg_bytes);
      end
      total = CNT_W'(4) + CNT_W'(arg_cnt);
      frame_sum = req_port.address + req_port.opcode;
      for (int i = 0; i < MAX_ARG_BYTES; i++) begin
         arg_b[i] = BYTE_ZERO;
         if (i < int'(arg_cnt)) begin
            pos = int'(arg_cnt) - 1 - i;
            arg_b[i] = 8'(req_port.arg_value >> (8 * pos));
         end
         frame_sum = frame_sum + arg_b[i];
      end
      if (int'(req_port.response_length) > MAX_REPLY_BYTES) begin
         rlen_sat = 4'(MAX_REPLY_BYTES);
      end else begin
         rlen_sat = req_port.response_length;
      end
   end

   assign rx_sum  = reply_sum_ff + req_port.rx_byte;
   assign rem_dec = (reply_remaining_ff != 4'd0) ? reply_remaining_ff - 4'd1
                                                 : reply_remaining_ff;

   always_comb begin
      reply_active_in    = reply_active_ff;
      reply_remaining_in = reply_remaining_ff;
      reply_first_in     = reply_first_ff;
      reply_sum_in       = reply_sum_ff;
      wk_valid_in        = wk_valid_ff;
      wk_kind_in         = wk_kind_ff;
      wk_bytes_in        = wk_bytes_ff;
      wk_idx_in          = wk_idx_ff;
      wk_last_idx_in     = wk_last_idx_ff;
      wk_end_in          = wk_end_ff;
      wk_status_in       = wk_status_ff;
      out_valid_in       = out_valid_ff;
      out_kind_in        = out_kind_ff;
      out_byte_in        = out_byte_ff;
      out_last_in        = out_last_ff;
      out_status_in      = out_status_ff;

      // advance the output register from the work register
      if (adv) begin
         out_valid_in  = wk_valid_ff;
         out_kind_in   = wk_kind_ff;
         out_byte_in   = wk_bytes_ff[wk_idx_ff];
         out_last_in   = wk_at_last && wk_end_ff;
         out_status_in = wk_at_last ? wk_status_ff : STATUS_OK;
         if (wk_valid_ff) begin
            if (wk_at_last) begin
               wk_valid_in = 1'b0;
            end else begin
               wk_idx_in = wk_idx_ff + IDX_W'(1);
            end
         end
      end

      if (req_fire) begin
         if (req_port.func == FUNC_CMD) begin
            wk_valid_in    = 1'b1;
            wk_kind_in     = KIND_TX;
            wk_idx_in      = '0;
            wk_last_idx_in = IDX_W'(total - CNT_W'(1));
            wk_end_in      = 1'b1;
            wk_status_in   = STATUS_OK;
            wk_bytes_in[0] = req_port.address;
            wk_bytes_in[1] = BYTE_ZERO - frame_sum;
            wk_bytes_in[2] = BYTE_ZERO;
            wk_bytes_in[3] = req_port.opcode;
            for (int i = 0; i < MAX_ARG_BYTES; i++) begin
               wk_bytes_in[4 + i] = arg_b[i];
            end
            reply_active_in    = (rlen_sat != 4'd0);
            reply_remaining_in = rlen_sat;
            reply_first_in     = (rlen_sat != 4'd0);
            reply_sum_in       = BYTE_ZERO;
         end else if (reply_active_ff) begin
            wk_valid_in    = 1'b1;
            wk_kind_in     = KIND_RX;
            wk_idx_in      = '0;
            wk_last_idx_in = '0;
            wk_end_in      = 1'b1;
            wk_bytes_in[0] = req_port.rx_byte;
            if (reply_first_ff && req_port.rx_byte != BYTE_ZERO
                && req_port.rx_byte != BYTE_ONE) begin
               wk_status_in       = STATUS_DEV;
               reply_active_in    = 1'b0;
               reply_remaining_in = 4'd0;
               reply_first_in     = 1'b0;
               reply_sum_in       = BYTE_ZERO;
            end else begin
               reply_first_in     = 1'b0;
               reply_remaining_in = rem_dec;
               if (rem_dec == 4'd0) begin
                  wk_status_in    = (rx_sum == BYTE_ZERO) ? STATUS_OK : STATUS_CSUM;
                  reply_active_in = 1'b0;
                  reply_sum_in    = BYTE_ZERO;
               end else begin
                  wk_end_in       = 1'b0;
                  wk_status_in    = STATUS_OK;
                  reply_sum_in    = rx_sum;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_active_ff    <= 1'b0;
         reply_remaining_ff <= 4'd0;
         reply_first_ff     <= 1'b0;
         reply_sum_ff       <= BYTE_ZERO;
         wk_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         reply_active_ff    <= reply_active_in;
         reply_remaining_ff <= reply_remaining_in;
         reply_first_ff     <= reply_first_in;
         reply_sum_ff       <= reply_sum_in;
         wk_valid_ff        <= wk_valid_in;
         out_valid_ff       <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_kind_ff     <= wk_kind_in;
      wk_bytes_ff    <= wk_bytes_in;
      wk_idx_ff      <= wk_idx_in;
      wk_last_idx_ff <= wk_last_idx_in;
      wk_end_ff      <= wk_end_in;
      wk_status_ff   <= wk_status_in;
      out_kind_ff    <= out_kind_in;
      out_byte_ff    <= out_byte_in;
      out_last_ff    <= out_last_in;
      out_status_ff  <= out_status_in;
   end

endmodule
